// ===== hw/rtl/rfd_pkg.sv =====
// Package for the response frame deframer: payload structs, phase and
// micro-program encodings, and the micro-program table. No dependencies.
`default_nettype none

package rfd_pkg;

  localparam int MAX_PAYLOAD_DEF = 32;
  localparam int CFG_IDX_W       = 8;
  localparam int UPC_W           = 5;

  typedef struct packed {
    logic       cmd;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] frame_type;
    logic       has_data;
    logic [7:0] data;
    logic       last;
  } out_item_t;

  typedef enum logic [2:0] {
    PH_HUNT, PH_ID, PH_LEN, PH_TYPE, PH_BODY
  } phase_t;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_CSUM    = 3'd1;
  localparam logic [2:0] ST_LEN     = 3'd2;
  localparam logic [2:0] ST_TIMEOUT = 3'd3;
  localparam logic [2:0] ST_OVER    = 3'd4;

  localparam logic       CMD_BYTE    = 1'b0;
  localparam logic       CMD_TIMEOUT = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_HEAD = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_ID   = CFG_IDX_W'(1);

  typedef enum logic [1:0] {
    NX_SEQ, NX_JUMP, NX_CJUMP, NX_DISPATCH
  } nxt_t;

  typedef enum logic [2:0] {
    C_NOT_ACCEPT, C_LEN_SHORT, C_BODY_LAST, C_OVF, C_SUM_BAD, C_COUNT_ZERO,
    C_NOT_LAST, C_NONE
  } cond_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_LATCH, OP_HEAD, OP_ID, OP_LEN, OP_TYPE, OP_BODY_INIT,
    OP_STORE, OP_END, OP_EMIT, OP_EMIT_TMO, OP_RD_START, OP_EMIT_DATA
  } op_t;

  typedef struct packed {
    nxt_t             nxt;
    cond_t            cond;
    logic [UPC_W-1:0] target;
    op_t              op;
    logic [2:0]       st;
    logic             ready;
    logic             wait_out;
  } ctrl_t;

  // micro-program step addresses
  localparam logic [UPC_W-1:0] U_WAIT   = UPC_W'(0);
  localparam logic [UPC_W-1:0] U_DISP   = UPC_W'(1);
  localparam logic [UPC_W-1:0] U_HEAD   = UPC_W'(2);
  localparam logic [UPC_W-1:0] U_ID     = UPC_W'(3);
  localparam logic [UPC_W-1:0] U_LEN    = UPC_W'(4);
  localparam logic [UPC_W-1:0] U_TYPE   = UPC_W'(5);
  localparam logic [UPC_W-1:0] U_BINIT  = UPC_W'(6);
  localparam logic [UPC_W-1:0] U_ELEN   = UPC_W'(7);
  localparam logic [UPC_W-1:0] U_ETMO   = UPC_W'(8);
  localparam logic [UPC_W-1:0] U_BODY   = UPC_W'(9);
  localparam logic [UPC_W-1:0] U_STORE  = UPC_W'(10);
  localparam logic [UPC_W-1:0] U_END    = UPC_W'(11);
  localparam logic [UPC_W-1:0] U_CSCHK  = UPC_W'(12);
  localparam logic [UPC_W-1:0] U_NCHK   = UPC_W'(13);
  localparam logic [UPC_W-1:0] U_RDST   = UPC_W'(14);
  localparam logic [UPC_W-1:0] U_DATA   = UPC_W'(15);
  localparam logic [UPC_W-1:0] U_DONE   = UPC_W'(16);
  localparam logic [UPC_W-1:0] U_EOVR   = UPC_W'(17);
  localparam logic [UPC_W-1:0] U_ECSUM  = UPC_W'(18);
  localparam logic [UPC_W-1:0] U_EOK    = UPC_W'(19);

  function automatic ctrl_t mk(nxt_t n, cond_t c, logic [UPC_W-1:0] t, op_t o,
                               logic [2:0] s, logic r, logic w);
    ctrl_t cw;
    cw.nxt      = n;
    cw.cond     = c;
    cw.target   = t;
    cw.op       = o;
    cw.st       = s;
    cw.ready    = r;
    cw.wait_out = w;
    return cw;
  endfunction

  function automatic ctrl_t ucode(logic [UPC_W-1:0] upc);
    ctrl_t cw;
    unique case (upc)
      U_WAIT:  cw = mk(NX_CJUMP, C_NOT_ACCEPT, U_WAIT, OP_LATCH, ST_OK, 1'b1, 1'b0);
      U_DISP:  cw = mk(NX_DISPATCH, C_NONE, U_WAIT, OP_NONE, ST_OK, 1'b0, 1'b0);
      U_HEAD:  cw = mk(NX_JUMP, C_NONE, U_WAIT, OP_HEAD, ST_OK, 1'b0, 1'b0);
      U_ID:    cw = mk(NX_JUMP, C_NONE, U_WAIT, OP_ID, ST_OK, 1'b0, 1'b0);
      U_LEN:   cw = mk(NX_JUMP, C_NONE, U_WAIT, OP_LEN, ST_OK, 1'b0, 1'b0);
      U_TYPE:  cw = mk(NX_CJUMP, C_LEN_SHORT, U_ELEN, OP_TYPE, ST_OK, 1'b0, 1'b0);
      U_BINIT: cw = mk(NX_JUMP, C_NONE, U_WAIT, OP_BODY_INIT, ST_OK, 1'b0, 1'b0);
      U_ELEN:  cw = mk(NX_JUMP, C_NONE, U_WAIT, OP_EMIT, ST_LEN, 1'b0, 1'b1);
      U_ETMO:  cw = mk(NX_JUMP, C_NONE, U_WAIT, OP_EMIT_TMO, ST_TIMEOUT, 1'b0, 1'b1);
      U_BODY:  cw = mk(NX_CJUMP, C_BODY_LAST, U_END, OP_NONE, ST_OK, 1'b0, 1'b0);
      U_STORE: cw = mk(NX_JUMP, C_NONE, U_WAIT, OP_STORE, ST_OK, 1'b0, 1'b0);
      U_END:   cw = mk(NX_CJUMP, C_OVF, U_EOVR, OP_END, ST_OK, 1'b0, 1'b0);
      U_CSCHK: cw = mk(NX_CJUMP, C_SUM_BAD, U_ECSUM, OP_NONE, ST_OK, 1'b0, 1'b0);
      U_NCHK:  cw = mk(NX_CJUMP, C_COUNT_ZERO, U_EOK, OP_NONE, ST_OK, 1'b0, 1'b0);
      U_RDST:  cw = mk(NX_SEQ, C_NONE, U_WAIT, OP_RD_START, ST_OK, 1'b0, 1'b0);
      U_DATA:  cw = mk(NX_CJUMP, C_NOT_LAST, U_DATA, OP_EMIT_DATA, ST_OK, 1'b0, 1'b1);
      U_DONE:  cw = mk(NX_JUMP, C_NONE, U_WAIT, OP_NONE, ST_OK, 1'b0, 1'b0);
      U_EOVR:  cw = mk(NX_JUMP, C_NONE, U_WAIT, OP_EMIT, ST_OVER, 1'b0, 1'b1);
      U_ECSUM: cw = mk(NX_JUMP, C_NONE, U_WAIT, OP_EMIT, ST_CSUM, 1'b0, 1'b1);
      U_EOK:   cw = mk(NX_JUMP, C_NONE, U_WAIT, OP_EMIT, ST_OK, 1'b0, 1'b1);
      default: cw = mk(NX_JUMP, C_NONE, U_WAIT, OP_NONE, ST_OK, 1'b0, 1'b0);
    endcase
    return cw;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/response_frame_deframer_core.sv =====
// Response frame deframer, top level: micro-program sequencer and datapath.
// Depends on rfd_pkg and rfd_ram.
//
// Use: received bytes and timeout events enter on in_valid/in_ready with
// in_item; result items leave on out_valid/out_ready with out_item. The
// head and id bytes are set through the cfg channel (index 0 head, 1 id),
// always ready; write only while the block is idle.
// Pacing: one micro-program step per cycle, save while an emitting step is held
// by a stalled receiver. Each transfer runs through the wait step, the dispatch
// step and the steps of its phase before in_ready is high again; a good frame's
// checksum byte runs through the body, end, checksum and count checks, the RAM
// read start, one step per payload entry handed over and a closing step; the
// registered RAM read port and the single output register set that pace.
// Reset returns to hunting for the head byte with head 255 and id 251,
// drops out_valid and leaves the payload RAM contents as they are.
// When the receiver stalls, the result stays in the output register and
// the sequencer holds on its emitting step; no input is taken meanwhile.
`default_nettype none

module response_frame_deframer_core #(
  parameter int MAX_PAYLOAD = rfd_pkg::MAX_PAYLOAD_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire rfd_pkg::in_item_t              in_item,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output rfd_pkg::out_item_t                  out_item,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [rfd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [7:0]                     cfg_data
);
  import rfd_pkg::*;

  localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

  logic [7:0]       head_value, id_value;
  logic [UPC_W-1:0] upc, upc_next, disp_target;
  ctrl_t            cw;
  phase_t           phase;
  logic             cmd_q;
  logic [7:0]       rx_q;
  logic [7:0]       length_byte, type_byte, running_sum, body_count, rd_idx;
  logic             overflowed;
  logic             out_busy, go, accept, cond_true, last_item, room, emit;
  logic             ram_we;
  logic [AW-1:0]    ram_raddr;
  logic [7:0]       ram_q;

  assign cw        = ucode(upc);
  assign in_ready  = cw.ready && !rst;
  assign accept    = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_busy  = out_valid && !out_ready;
  assign go        = !(cw.wait_out && out_busy);
  assign last_item = ({1'b0, rd_idx} + 9'd1) == {1'b0, body_count};
  assign room      = body_count < 8'(MAX_PAYLOAD);
  assign emit      = go && (cw.op == OP_EMIT || cw.op == OP_EMIT_TMO ||
                            cw.op == OP_EMIT_DATA);

  always_comb begin
    unique case (cw.cond)
      C_NOT_ACCEPT: cond_true = !accept;
      C_LEN_SHORT:  cond_true = length_byte < 8'd3;
      // more body bytes follow while count + 1 < length - 2
      C_BODY_LAST:  cond_true = !(({1'b0, body_count} + 9'd3) < {1'b0, length_byte});
      C_OVF:        cond_true = overflowed;
      C_SUM_BAD:    cond_true = running_sum != rx_q;
      C_COUNT_ZERO: cond_true = body_count == 8'd0;
      C_NOT_LAST:   cond_true = !last_item;
      C_NONE:       cond_true = 1'b0;
      default:      cond_true = 1'b0;
    endcase
  end

  always_comb begin
    if (cmd_q == CMD_TIMEOUT) begin
      disp_target = U_ETMO;
    end else begin
      unique case (phase)
        PH_HUNT: disp_target = U_HEAD;
        PH_ID:   disp_target = U_ID;
        PH_LEN:  disp_target = U_LEN;
        PH_TYPE: disp_target = U_TYPE;
        PH_BODY: disp_target = U_BODY;
        default: disp_target = U_HEAD;
      endcase
    end
  end

  always_comb begin
    if (!go) begin
      upc_next = upc;
    end else begin
      unique case (cw.nxt)
        NX_SEQ:      upc_next = upc + UPC_W'(1);
        NX_JUMP:     upc_next = cw.target;
        NX_CJUMP:    upc_next = cond_true ? cw.target : upc + UPC_W'(1);
        NX_DISPATCH: upc_next = disp_target;
        default:     upc_next = U_WAIT;
      endcase
    end
  end

  // read address runs one ahead while a data item is handed over
  always_comb begin
    if (cw.op == OP_RD_START) begin
      ram_raddr = '0;
    end else if (cw.op == OP_EMIT_DATA && go) begin
      ram_raddr = AW'(rd_idx + 8'd1);
    end else begin
      ram_raddr = rd_idx[AW-1:0];
    end
  end

  assign ram_we = (cw.op == OP_STORE) && room;

  rfd_ram #(
    .WIDTH (8),
    .DEPTH (MAX_PAYLOAD)
  ) u_payload_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (body_count[AW-1:0]),
    .wdata (rx_q),
    .raddr (ram_raddr),
    .rdata (ram_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      upc        <= U_WAIT;
      phase      <= PH_HUNT;
      out_valid  <= 1'b0;
      head_value <= 8'd255;
      id_value   <= 8'd251;
      overflowed <= 1'b0;
    end else begin
      upc <= upc_next;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_HEAD) begin
          head_value <= cfg_data;
        end else if (cfg_index == REG_ID) begin
          id_value <= cfg_data;
        end
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (go) begin
        unique case (cw.op)
          OP_LATCH: begin
            if (accept) begin
              cmd_q <= in_item.cmd;
              rx_q  <= in_item.rx_byte;
            end
          end
          OP_HEAD: phase <= (rx_q == head_value) ? PH_ID : PH_HUNT;
          OP_ID:   phase <= (rx_q == id_value) ? PH_LEN : PH_HUNT;
          OP_LEN: begin
            length_byte <= rx_q;
            phase       <= PH_TYPE;
          end
          OP_TYPE: type_byte <= rx_q;
          OP_BODY_INIT: begin
            running_sum <= length_byte + type_byte;
            body_count  <= 8'd0;
            overflowed  <= 1'b0;
            phase       <= PH_BODY;
          end
          OP_STORE: begin
            running_sum <= running_sum + rx_q;
            if (!room) begin
              overflowed <= 1'b1;
            end
            body_count <= body_count + 8'd1;
          end
          OP_END: phase <= PH_HUNT;
          OP_EMIT: begin
            phase               <= PH_HUNT;
            out_item.status     <= cw.st;
            out_item.frame_type <= type_byte;
            out_item.has_data   <= 1'b0;
            out_item.data       <= 8'd0;
            out_item.last       <= 1'b1;
          end
          OP_EMIT_TMO: begin
            phase               <= PH_HUNT;
            out_item.status     <= cw.st;
            out_item.frame_type <= (phase == PH_BODY) ? type_byte : 8'd0;
            out_item.has_data   <= 1'b0;
            out_item.data       <= 8'd0;
            out_item.last       <= 1'b1;
          end
          OP_RD_START: rd_idx <= 8'd0;
          OP_EMIT_DATA: begin
            out_item.status     <= ST_OK;
            out_item.frame_type <= type_byte;
            out_item.has_data   <= 1'b1;
            out_item.data       <= ram_q;
            out_item.last       <= last_item;
            rd_idx              <= rd_idx + 8'd1;
          end
          OP_NONE: ;
          default: ;
        endcase
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/rfd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Self-contained; no package needed.
`default_nettype none

module rfd_ram #(
  parameter  int WIDTH = 8,
  parameter  int DEPTH = 32,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/rfd_checker.sv =====
// Port-level checker for response_frame_deframer_core, bound to the top level.
// Depends on rfd_pkg.
`default_nettype none

module rfd_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire rfd_pkg::out_item_t out_item
);
  import rfd_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result changed while stalled");

  // in_ready drops after each transfer
  a_in_gap: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken on consecutive cycles");

  // only payload items may leave a run open
  a_run_open: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_item.last |-> out_item.has_data && out_item.status == ST_OK)
    else $error("open run on a status item");

  // reset empties the output register
  a_rst_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result present after reset");

endmodule

bind response_frame_deframer_core rfd_checker u_rfd_checker (.*);

`default_nettype wire

// ===== dv/tb_response_frame_deframer_core.sv =====
// Testbench for response_frame_deframer_core: sends frames, broken frames and
// noise, predicts every result item and checks it field by field.
// Depends on rfd_pkg and the deframer RTL only.
`timescale 1ns / 100ps

module tb_response_frame_deframer_core;
  import rfd_pkg::*;

  localparam int MAX_PAYLOAD  = MAX_PAYLOAD_DEF;
  localparam int BLOCK_LAT    = 8;
  localparam int DRAIN_CYCLES = MAX_PAYLOAD + 16;
  localparam int END_WAIT     = 20000;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int RAND_ITEMS   = 65;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = CFG_IDX_W'(255);

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_item = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_item;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [7:0] cfg_data = '0;

  response_frame_deframer_core dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // expected deframer state, mirrored from the register writes and inputs
  logic [7:0] head_reg = 8'hFF;
  logic [7:0] id_reg   = 8'hFB;
  phase_t     rx_phase = PH_HUNT;
  logic [7:0] length_q = '0;
  logic [7:0] frame_type_q = '0;
  logic [7:0] sum_q = '0;
  int         body_count = 0;
  logic       overflow_q = 1'b0;
  logic [7:0] payload_q [MAX_PAYLOAD];

  out_item_t awaited_items [$];

  int send_gap_pct = 0;
  int sink_stall_pct = 0;
  int err_count = 0;
  int items_sent = 0;
  int noise_sent = 0;
  int frames_sent = 0;
  int results_checked = 0;
  int cycle_count = 0;

  task automatic flag_error(string msg);
    $display("ERROR cycle %0d: %s", cycle_count, msg);
    err_count++;
  endtask

  function automatic out_item_t make_result(logic [2:0] st, logic [7:0] ft, logic hd,
                                            logic [7:0] d, logic lst);
    out_item_t r;
    r.status     = st;
    r.frame_type = ft;
    r.has_data   = hd;
    r.data       = d;
    r.last       = lst;
    return r;
  endfunction

  function automatic void queue_result(out_item_t r);
    awaited_items = {awaited_items, r};
  endfunction

  function automatic void deframe_step(in_item_t it);
    logic [7:0] b;
    b = it.rx_byte;
    if (it.cmd == CMD_TIMEOUT) begin
      // type byte only reported once the body has started
      queue_result(make_result(ST_TIMEOUT,
        (rx_phase == PH_BODY) ? frame_type_q : 8'h00, 1'b0, 8'h00, 1'b1));
      rx_phase = PH_HUNT;
    end else begin
      case (rx_phase)
        PH_ID: rx_phase = (b == id_reg) ? PH_LEN : PH_HUNT;
        PH_LEN: begin
          length_q = b;
          rx_phase = PH_TYPE;
        end
        PH_TYPE: begin
          frame_type_q = b;
          if (length_q < 8'd3) begin
            rx_phase = PH_HUNT;
            queue_result(make_result(ST_LEN, b, 1'b0, 8'h00, 1'b1));
          end else begin
            sum_q      = length_q + frame_type_q;
            body_count = 0;
            overflow_q = 1'b0;
            rx_phase   = PH_BODY;
          end
        end
        PH_BODY: begin
          if (body_count + 1 < int'(length_q) - 2) begin
            sum_q = sum_q + b;
            if (body_count < MAX_PAYLOAD) payload_q[body_count] = b;
            else overflow_q = 1'b1;
            body_count++;
          end else begin
            rx_phase = PH_HUNT;
            if (overflow_q) begin
              queue_result(make_result(ST_OVER, frame_type_q, 1'b0, 8'h00, 1'b1));
            end else if (sum_q != b) begin
              queue_result(make_result(ST_CSUM, frame_type_q, 1'b0, 8'h00, 1'b1));
            end else if (body_count == 0) begin
              queue_result(make_result(ST_OK, frame_type_q, 1'b0, 8'h00, 1'b1));
            end else begin
              for (int i = 0; i < body_count; i++)
                queue_result(make_result(ST_OK, frame_type_q, 1'b1, payload_q[i],
                                         i == body_count - 1));
            end
          end
        end
        default: rx_phase = (b == head_reg) ? PH_ID : PH_HUNT;
      endcase
    end
  endfunction

  // one input transfer; valid is left high for a following back-to-back item
  task automatic send_item(logic cmd, logic [7:0] value);
    in_item_t it;
    it.cmd     = cmd;
    it.rx_byte = value;
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (!in_ready);
    deframe_step(it);
    items_sent++;
  endtask

  // drop valid, let every awaited result arrive and the sequencer settle
  task automatic settle_block();
    in_valid <= 1'b0;
    @(posedge clk);
    while (awaited_items.size() != 0) @(posedge clk);
    repeat (BLOCK_LAT) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_HEAD) head_reg = value;
    else if (idx == REG_ID) id_reg = value;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_frame(int npay, logic [7:0] ftype, bit bad_sum);
    logic [7:0] len, csum, b;
    len  = 8'(npay + 3);
    csum = len + ftype;
    send_item(CMD_BYTE, head_reg);
    send_item(CMD_BYTE, id_reg);
    send_item(CMD_BYTE, len);
    send_item(CMD_BYTE, ftype);
    for (int i = 0; i < npay; i++) begin
      b    = 8'($urandom);
      csum = csum + b;
      send_item(CMD_BYTE, b);
    end
    if (bad_sum) csum = csum ^ 8'($urandom_range(1, 255));
    send_item(CMD_BYTE, csum);
    frames_sent++;
  endtask

  task automatic send_short_len(logic [7:0] len, logic [7:0] ftype);
    send_item(CMD_BYTE, head_reg);
    send_item(CMD_BYTE, id_reg);
    send_item(CMD_BYTE, len);
    send_item(CMD_BYTE, ftype);
    frames_sent++;
  endtask

  // k bytes of a long frame, then a timeout; k = 0 times out while hunting
  task automatic send_truncated(int k);
    logic [7:0] b;
    for (int i = 0; i < k; i++) begin
      case (i)
        0: b = head_reg;
        1: b = id_reg;
        2: b = 8'($urandom_range(12, 255));
        default: b = 8'($urandom);
      endcase
      send_item(CMD_BYTE, b);
    end
    send_item(CMD_TIMEOUT, 8'($urandom));
  endtask

  function automatic int pick_payload_len();
    int r;
    r = $urandom_range(99);
    if (r < 70) return $urandom_range(0, 6);
    if (r < 93) return $urandom_range(7, MAX_PAYLOAD);
    return $urandom_range(MAX_PAYLOAD + 1, MAX_PAYLOAD + 8);
  endfunction

  task automatic test_special_cases();
    send_item(CMD_TIMEOUT, 8'hFF);            // timeout while hunting
    send_frame(0, 8'h00, 1'b0);               // good empty frame
    send_frame(1, 8'hFF, 1'b0);
    send_short_len(8'd2, 8'hA5);
    send_short_len(8'd0, 8'h00);
    send_frame(2, 8'h3C, 1'b1);               // checksum mismatch
    // second head byte fails the id check and is not taken as a new head
    send_item(CMD_BYTE, head_reg);
    send_item(CMD_BYTE, head_reg);
    send_item(CMD_BYTE, id_reg);
    send_truncated(5);                        // timeout inside the body
    send_truncated(1);                        // timeout before the type byte
  endtask

  task automatic test_overflow();
    send_frame(MAX_PAYLOAD + 1, 8'h81, 1'b0);
    send_frame(MAX_PAYLOAD + 1, 8'h7E, 1'b1); // overflow wins over checksum
  endtask

  task automatic test_longest_frames();
    send_frame(MAX_PAYLOAD, 8'h5A, 1'b0);     // largest good payload
    send_frame(72, 8'hC3, 1'b0);              // runs far past the store
  endtask

  task automatic test_config_settings();
    settle_block();
    write_reg(REG_HEAD, 8'h00);
    write_reg(REG_ID, 8'h00);
    send_frame(3, 8'h11, 1'b0);
    settle_block();
    write_reg(REG_HEAD, 8'hFF);
    write_reg(REG_ID, 8'hFF);
    send_frame(2, 8'h22, 1'b0);
    settle_block();
    write_reg(REG_SPARE, 8'h00);              // out-of-range index, no effect
    write_reg(CFG_IDX_W'($urandom_range(2, 254)), 8'($urandom));
    send_frame(1, 8'h33, 1'b0);
    settle_block();
    write_reg(REG_HEAD, 8'hFF);
    write_reg(REG_ID, 8'hFB);
  endtask

  task automatic test_random_traffic(int budget, int gap_pct, int stall_pct);
    int start, kind;
    settle_block();
    send_gap_pct   = gap_pct;
    sink_stall_pct = stall_pct;
    write_reg(REG_HEAD, 8'($urandom));
    write_reg(REG_ID, 8'($urandom));
    start = items_sent - noise_sent;
    while (items_sent - noise_sent - start < budget) begin
      kind = $urandom_range(99);
      if (kind < 55) begin
        send_frame(pick_payload_len(), 8'($urandom), 1'b0);
      end else if (kind < 65) begin
        send_frame(pick_payload_len(), 8'($urandom), 1'b1);
      end else if (kind < 72) begin
        send_short_len(8'($urandom_range(0, 2)), 8'($urandom));
      end else if (kind < 80) begin
        send_truncated($urandom_range(0, 8));
      end else if (kind < 87) begin
        send_item(CMD_BYTE, head_reg);
        send_item(CMD_BYTE, id_reg ^ 8'($urandom_range(1, 255)));
      end else if (kind < 92) begin
        send_item(CMD_TIMEOUT, 8'($urandom));
      end else begin
        send_item(CMD_BYTE, 8'($urandom));
        noise_sent++;
      end
      if ($urandom_range(99) < 4) settle_block();
    end
  endtask

  always @(posedge clk) out_ready <= ($urandom_range(99) >= sink_stall_pct);

  always @(posedge clk) begin
    out_item_t want;
    if (!rst && out_valid && out_ready) begin
      if (awaited_items.size() == 0) begin
        flag_error($sformatf("result with none awaited: %h", out_item));
      end else begin
        want = awaited_items.pop_front();
        if (out_item.status !== want.status)
          flag_error($sformatf("status %0d, want %0d", out_item.status, want.status));
        if (out_item.frame_type !== want.frame_type)
          flag_error($sformatf("frame_type %h, want %h", out_item.frame_type, want.frame_type));
        if (out_item.has_data !== want.has_data)
          flag_error($sformatf("has_data %b, want %b", out_item.has_data, want.has_data));
        if (out_item.data !== want.data)
          flag_error($sformatf("data %h, want %h", out_item.data, want.data));
        if (out_item.last !== want.last)
          flag_error($sformatf("last %b, want %b", out_item.last, want.last));
        results_checked++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    int waited;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    send_gap_pct   = 10;
    sink_stall_pct = 87;
    test_config_settings();
    test_special_cases();
    test_overflow();
    test_longest_frames();
    test_random_traffic(RAND_ITEMS, 10, 87);
    test_random_traffic(RAND_ITEMS, 87, 10);
    test_random_traffic(RAND_ITEMS, 0, 0);

    in_valid <= 1'b0;
    waited = 0;
    while (awaited_items.size() != 0 && waited < END_WAIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (awaited_items.size() != 0)
      flag_error($sformatf("%0d result(s) never arrived", awaited_items.size()));

    $display("%0d frames and %0d input transfers sent, %0d result transfers checked",
             frames_sent, items_sent, results_checked);
    $display("covered good, short, bad-checksum, overflow and timed-out frames under stalls");
    if (err_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d error(s)", err_count);
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/rfd_pkg.sv
hw/rtl/rfd_ram.sv
hw/rtl/response_frame_deframer_core.sv
hw/rtl/rfd_checker.sv
dv/tb_response_frame_deframer_core.sv
